// ===== rtl/ts_ring_unit_packer_macros.svh =====
// ----------------------------------------------------------------------------
// ts_ring_unit_packer_macros
// Assertion macros used by the ring unit packer datapath.
// ----------------------------------------------------------------------------
`ifndef TS_RING_UNIT_PACKER_MACROS_SVH
`define TS_RING_UNIT_PACKER_MACROS_SVH

`ifndef ASSERT_OFF
// checked only while reset is released
`define TRUP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked also during reset
`define TRUP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TRUP_ASSERT(lbl, clk, rst_n, prop, msg)
`define TRUP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/trup_pkg.sv =====
// ----------------------------------------------------------------------------
// trup_pkg
// Types and constants of the ring unit packer.
// ----------------------------------------------------------------------------
package trup_pkg;

	localparam int IDX_W  = 12;
	localparam int REQ_W  = 14;
	localparam int PAY_W  = 11;
	localparam int SIZE_W = 8;
	localparam int CFG_W  = 12;

	localparam logic [1:0] ST_FILLED = 2'd0;
	localparam logic [1:0] ST_NONE   = 2'd1;
	localparam logic [1:0] ST_SMALL  = 2'd2;
	localparam logic [1:0] ST_MODE   = 2'd3;

	localparam logic [1:0] CFG_BUF_MODE  = 2'd0;
	localparam logic [1:0] CFG_UNIT_CNT  = 2'd1;
	localparam logic [1:0] CFG_UNIT_SIZE = 2'd2;
	localparam logic [1:0] CFG_LOW_MARK  = 2'd3;

	localparam logic [1:0] BUF_MODE_DMA = 2'd3;

	localparam int HEADER_BYTES = 8;

	typedef struct packed {
		logic       load_req;
		logic       calc_free;
		logic       div_start;
		logic       div_sel_len;
		logic       take_per;
		logic       take_q;
		logic       take_n;
		logic       take_pay;
		logic       load_err;
		logic [1:0] err_status;
		logic       load_unit;
	} trup_cmd_t;

	typedef struct packed {
		logic mode_ok;
		logic nothing;
		logic too_small;
		logic div_done;
		logic load_ok;
		logic more;
	} trup_stat_t;

endpackage

// ===== rtl/ts_ring_unit_packer.sv =====
// ----------------------------------------------------------------------------
// ts_ring_unit_packer
// Producer side of a wrap-bit ring of fixed-size units.
// ----------------------------------------------------------------------------
// Each request word (consumer read pointer and byte length) yields one or
// more descriptor words, one per unit filled, or a single error word. A
// request is taken only when the sequencer is idle; the output register
// lets the next request enter while the last descriptor waits. A request
// that ends in an error leaves from the decide step. Otherwise the unit
// capacity and the packet count come one after the other from a shared
// reciprocal-multiply divider, and each descriptor then passes through
// the min, multiply and emit steps, plus any wait while the output side
// stalls.
module ts_ring_unit_packer #(
	parameter int unsigned PACKET_BYTES          = 188,
	parameter int unsigned MAX_UNITS_PER_REQUEST = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// read_index[11:0], read_wrap[12], request_bytes[26:13], zero[31:27]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status[1:0], unit_index[13:2], payload_bytes[24:14], accepted_bytes[38:25],
	// next_write_index[50:39], next_write_wrap[51], free_units[63:52],
	// space_ok[64], zero[71:65]
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import trup_pkg::*;

	trup_cmd_t        cmd;
	trup_stat_t       stat;
	logic [1:0]       o_status;
	logic [IDX_W-1:0] o_unit_index;
	logic [PAY_W-1:0] o_payload;
	logic [REQ_W-1:0] o_accepted;
	logic [IDX_W-1:0] o_next_index;
	logic             o_next_wrap;
	logic [IDX_W-1:0] o_free;
	logic             o_space_ok;

	assign cfg_ready = 1'b1;

	trup_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	trup_dp #(
		.PACKET_BYTES          (PACKET_BYTES),
		.MAX_UNITS_PER_REQUEST (MAX_UNITS_PER_REQUEST)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rd_index     (s_axis_tdata[11:0]),
		.rd_wrap      (s_axis_tdata[12]),
		.req_bytes    (s_axis_tdata[26:13]),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.o_status     (o_status),
		.o_unit_index (o_unit_index),
		.o_payload    (o_payload),
		.o_accepted   (o_accepted),
		.o_next_index (o_next_index),
		.o_next_wrap  (o_next_wrap),
		.o_free       (o_free),
		.o_space_ok   (o_space_ok),
		.o_last       (m_axis_tlast)
	);

	assign m_axis_tdata = {7'b0000000, o_space_ok, o_free, o_next_wrap, o_next_index,
	                       o_accepted, o_payload, o_unit_index, o_status};

endmodule

// ===== rtl/trup_div.sv =====
// ----------------------------------------------------------------------------
// trup_div
// Division by a fixed divisor through reciprocal multiplication, result
// registered in the cycle after start.
// ----------------------------------------------------------------------------
module trup_div #(
	parameter int unsigned DIVISOR = 188
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [trup_pkg::REQ_W-1:0] dividend,
	output logic                      done,
	output logic [trup_pkg::REQ_W-1:0] quotient
);
	import trup_pkg::*;

	// shift wide enough that the reciprocal error stays below one step
	// for every dividend of REQ_W bits
	localparam int SH = REQ_W + $clog2(DIVISOR);
	localparam int MW = REQ_W + 1;
	localparam int PW = REQ_W + MW;
	localparam logic [MW-1:0] RECIP = MW'((2**SH + DIVISOR - 1) / DIVISOR);

	logic [PW-1:0]    prod;
	logic [REQ_W-1:0] quo_q;
	logic             done_q;

	assign prod = PW'(dividend) * PW'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= start;
	end

	always_ff @(posedge clk) begin
		if (start)
			quo_q <= REQ_W'(prod >> SH);
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== rtl/trup_ctrl.sv =====
// ----------------------------------------------------------------------------
// trup_ctrl
// Sequencer: free count, checks, two divisions, then one pass per unit.
// ----------------------------------------------------------------------------
module trup_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  trup_pkg::trup_stat_t   stat,
	output trup_pkg::trup_cmd_t    cmd
);
	import trup_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_FREE   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_DIVP   = 3'd3;
	localparam logic [2:0] S_DIVL   = 3'd4;
	localparam logic [2:0] S_MIN    = 3'd5;
	localparam logic [2:0] S_MUL    = 3'd6;
	localparam logic [2:0] S_EMIT   = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = S_FREE;
				end
			end
			S_FREE: begin
				cmd.calc_free = 1'b1;
				state_d       = S_DECIDE;
			end
			S_DECIDE: begin
				if (!stat.mode_ok || stat.nothing || stat.too_small) begin
					if (!stat.mode_ok)
						cmd.err_status = ST_MODE;
					else if (stat.nothing)
						cmd.err_status = ST_NONE;
					else
						cmd.err_status = ST_SMALL;
					if (stat.load_ok) begin
						cmd.load_err = 1'b1;
						state_d      = S_IDLE;
					end
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIVP;
				end
			end
			S_DIVP: begin
				if (stat.div_done) begin
					cmd.take_per    = 1'b1;
					cmd.div_start   = 1'b1;
					cmd.div_sel_len = 1'b1;
					state_d         = S_DIVL;
				end
			end
			S_DIVL: begin
				if (stat.div_done) begin
					cmd.take_q = 1'b1;
					state_d    = S_MIN;
				end
			end
			S_MIN: begin
				cmd.take_n = 1'b1;
				state_d    = S_MUL;
			end
			S_MUL: begin
				cmd.take_pay = 1'b1;
				state_d      = S_EMIT;
			end
			S_EMIT: begin
				if (stat.load_ok) begin
					cmd.load_unit = 1'b1;
					state_d       = stat.more ? S_MIN : S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign in_ready = (state_q == S_IDLE);

endmodule

// ===== rtl/trup_dp.sv =====
// ----------------------------------------------------------------------------
// trup_dp
// Datapath: registers, write pointer, free count, unit sizing, result word.
// ----------------------------------------------------------------------------
`include "ts_ring_unit_packer_macros.svh"

module trup_dp #(
	parameter int unsigned PACKET_BYTES          = 188,
	parameter int unsigned MAX_UNITS_PER_REQUEST = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [trup_pkg::CFG_W-1:0]  cfg_data,
	input  logic [trup_pkg::IDX_W-1:0]  rd_index,
	input  logic                        rd_wrap,
	input  logic [trup_pkg::REQ_W-1:0]  req_bytes,
	input  trup_pkg::trup_cmd_t         cmd,
	output trup_pkg::trup_stat_t        stat,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  o_status,
	output logic [trup_pkg::IDX_W-1:0]  o_unit_index,
	output logic [trup_pkg::PAY_W-1:0]  o_payload,
	output logic [trup_pkg::REQ_W-1:0]  o_accepted,
	output logic [trup_pkg::IDX_W-1:0]  o_next_index,
	output logic                        o_next_wrap,
	output logic [trup_pkg::IDX_W-1:0]  o_free,
	output logic                        o_space_ok,
	output logic                        o_last
);
	import trup_pkg::*;

	localparam int PK_W = 12;
	localparam int KW   = $clog2(MAX_UNITS_PER_REQUEST + 1);
	localparam logic [PK_W-1:0] PK     = PK_W'(PACKET_BYTES);
	localparam logic [PK_W:0]   PK_HDR = (PK_W+1)'(PACKET_BYTES + HEADER_BYTES);

	// configuration
	logic [1:0]        mode_q;
	logic [IDX_W-1:0]  ucnt_q;
	logic [SIZE_W-1:0] usize_code_q;
	logic [IDX_W-1:0]  mark_q;

	// pointer state
	logic [IDX_W-1:0] wi_q;
	logic             ww_q;

	// request working set
	logic [IDX_W-1:0] rd_idx_q;
	logic             rd_wrap_q;
	logic [REQ_W-1:0] len_q;
	logic [IDX_W-1:0] free_q;
	logic [PAY_W-1:0] per_q;
	logic [REQ_W-1:0] q_q;
	logic [PAY_W-1:0] n_q;
	logic [PAY_W-1:0] pay_q;
	logic [REQ_W-1:0] acc_q;
	logic [KW-1:0]    k_q;

	// result word
	logic             ov_q;
	logic [1:0]       st_q;
	logic [IDX_W-1:0] ui_q;
	logic [PAY_W-1:0] po_q;
	logic [REQ_W-1:0] ao_q;
	logic [IDX_W-1:0] ni_q;
	logic             nw_q;
	logic [IDX_W-1:0] fo_q;
	logic             sp_q;
	logic             last_q;

	logic [PAY_W-1:0]       usize;
	logic signed [REQ_W-1:0] d_wr;
	logic signed [REQ_W-1:0] f;
	logic                   f_ok;
	logic [REQ_W-1:0]       div_dividend;
	logic                   div_done;
	logic [REQ_W-1:0]       div_quo;
	logic [PAY_W+PK_W-1:0]  prod;
	logic [IDX_W:0]         wi_inc;
	logic                   wrap_hit;
	logic [IDX_W-1:0]       wi_nxt;
	logic                   ww_nxt;
	logic [REQ_W-1:0]       q_nxt;
	logic [IDX_W-1:0]       free_nxt;
	logic [KW-1:0]          k_nxt;
	logic [REQ_W-1:0]       acc_nxt;
	logic [IDX_W-1:0]       err_free;
	logic                   load_ok;

	assign usize = {usize_code_q, 3'b000};

	// free units: signed pointer distance, valid only within 1..unit_count
	assign d_wr = $signed({2'b00, rd_idx_q}) - $signed({2'b00, wi_q});
	assign f    = (rd_wrap_q != ww_q) ? d_wr : d_wr + $signed({2'b00, ucnt_q});
	assign f_ok = (f >= $signed(REQ_W'(1))) && (f <= $signed({2'b00, ucnt_q}));

	assign div_dividend = cmd.div_sel_len ? len_q
	                                      : {3'b000, usize - PAY_W'(HEADER_BYTES)};

	trup_div #(
		.DIVISOR (PACKET_BYTES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign prod = (PAY_W+PK_W)'(n_q) * (PAY_W+PK_W)'(PK);

	assign wi_inc   = {1'b0, wi_q} + (IDX_W+1)'(1);
	assign wrap_hit = wi_inc >= {1'b0, ucnt_q};
	assign wi_nxt   = wrap_hit ? '0 : wi_inc[IDX_W-1:0];
	assign ww_nxt   = ww_q ^ wrap_hit;

	assign q_nxt    = q_q - {3'b000, n_q};
	assign free_nxt = free_q - IDX_W'(1);
	assign k_nxt    = k_q + KW'(1);
	assign acc_nxt  = acc_q + {3'b000, pay_q};
	assign err_free = (cmd.err_status == ST_MODE) ? '0 : free_q;

	assign load_ok = !ov_q || out_ready;

	assign stat.mode_ok   = (mode_q == BUF_MODE_DMA);
	assign stat.nothing   = (len_q < {2'b00, PK}) || (free_q == '0);
	assign stat.too_small = ({2'b00, usize} < PK_HDR);
	assign stat.div_done  = div_done;
	assign stat.load_ok   = load_ok;
	assign stat.more      = (q_nxt != '0) && (free_nxt != '0)
	                        && (k_nxt < KW'(MAX_UNITS_PER_REQUEST));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= '0;
			ucnt_q       <= '0;
			usize_code_q <= '0;
			mark_q       <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BUF_MODE:  mode_q       <= cfg_data[1:0];
				CFG_UNIT_CNT:  ucnt_q       <= cfg_data;
				CFG_UNIT_SIZE: usize_code_q <= cfg_data[SIZE_W-1:0];
				CFG_LOW_MARK:  mark_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q <= '0;
			ww_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (cmd.load_unit) begin
				wi_q <= wi_nxt;
				ww_q <= ww_nxt;
			end
			if (cmd.load_err || cmd.load_unit)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			rd_idx_q  <= rd_index;
			rd_wrap_q <= rd_wrap;
			len_q     <= req_bytes;
			acc_q     <= '0;
			k_q       <= '0;
		end
		if (cmd.calc_free)
			free_q <= f_ok ? f[IDX_W-1:0] : '0;
		if (cmd.take_per)
			per_q <= div_quo[PAY_W-1:0];
		if (cmd.take_q)
			q_q <= div_quo;
		if (cmd.take_n)
			n_q <= (q_q < {3'b000, per_q}) ? q_q[PAY_W-1:0] : per_q;
		if (cmd.take_pay)
			pay_q <= prod[PAY_W-1:0];
		if (cmd.load_unit) begin
			q_q    <= q_nxt;
			free_q <= free_nxt;
			k_q    <= k_nxt;
			acc_q  <= acc_nxt;
			st_q   <= ST_FILLED;
			ui_q   <= wi_q;
			po_q   <= pay_q;
			ao_q   <= acc_nxt;
			ni_q   <= wi_nxt;
			nw_q   <= ww_nxt;
			fo_q   <= free_nxt;
			sp_q   <= free_nxt > mark_q;
			last_q <= !stat.more;
		end else if (cmd.load_err) begin
			st_q   <= cmd.err_status;
			ui_q   <= wi_q;
			po_q   <= '0;
			ao_q   <= '0;
			ni_q   <= wi_q;
			nw_q   <= ww_q;
			fo_q   <= err_free;
			sp_q   <= err_free > mark_q;
			last_q <= 1'b1;
		end
	end

	assign out_valid    = ov_q;
	assign o_status     = st_q;
	assign o_unit_index = ui_q;
	assign o_payload    = po_q;
	assign o_accepted   = ao_q;
	assign o_next_index = ni_q;
	assign o_next_wrap  = nw_q;
	assign o_free       = fo_q;
	assign o_space_ok   = sp_q;
	assign o_last       = last_q;

	// a filled unit always carries packets and the running total covers them
	`TRUP_ASSERT(a_fill_pay, clk, arst_n, (ov_q && st_q == ST_FILLED) |-> (po_q != '0 && ao_q >= {3'b000, po_q}), "filled unit without payload")
	// error results stand alone
	`TRUP_ASSERT(a_err_last, clk, arst_n, (ov_q && st_q != ST_FILLED) |-> last_q, "error result not marked last")
	// error results leave the write pointer alone
	`TRUP_ASSERT(a_err_ptr, clk, arst_n, cmd.load_err |=> ($stable(wi_q) && $stable(ww_q)), "write pointer moved on error")

endmodule
